[rtl/core/ivs_pkg.sv]
// ----------------------------------------------------------------------------
// ivs_pkg
// shared types and codes for the indexed vector store
// ----------------------------------------------------------------------------
`default_nettype none

package ivs_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned POS_W  = 10;
   localparam int unsigned FILL_W = 11;

   typedef enum logic [2:0] {
      REQ_PUSH  = 3'd0,
      REQ_POP   = 3'd1,
      REQ_GET   = 3'd2,
      REQ_SET   = 3'd3,
      REQ_ERASE = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2
   } status_code_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_ERASE
   } ivs_state_type;

   // one result item
   typedef struct packed {
      logic signed [WORD_W-1:0] word_out;
      logic [1:0]               status;
      logic [FILL_W-1:0]        fill_count;
   } ivs_rsp_type;

endpackage

`default_nettype wire

[rtl/core/ivs_mem.sv]
// ----------------------------------------------------------------------------
// ivs_mem
// entry memory: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module ivs_mem
   import ivs_pkg::*;
#(
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WORD_W-1:0]          wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WORD_W-1:0]          rd_data
);

   logic [WORD_W-1:0] mem_ff [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/ivs_ctrl.sv]
// ----------------------------------------------------------------------------
// ivs_ctrl
// request sequencer: fill count, memory access and the erase walk
// ----------------------------------------------------------------------------
`default_nettype none

module ivs_ctrl
   import ivs_pkg::*;
#(
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [2:0]                 req_type,
   input  wire logic [POS_W-1:0]           req_position,
   input  wire logic [WORD_W-1:0]          req_word_in,
   input  wire logic                       out_free,
   output logic                            done,
   output ivs_rsp_type                     result,
   output logic                            wr_en,
   output logic [$clog2(DEPTH)-1:0]        wr_addr,
   output logic [WORD_W-1:0]               wr_data,
   output logic [$clog2(DEPTH)-1:0]        rd_addr,
   input  wire logic [WORD_W-1:0]          rd_data
);

   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int unsigned EXT_W = (CNT_W > FILL_W) ? CNT_W : FILL_W;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   ivs_state_type   state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] walk_ff, walk_in;

   logic             accept;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] count_ext;
   logic [CMP_W:0]   pos_p1;
   logic             in_range;
   logic             more_above;
   logic [CNT_W-1:0] count_dec;
   logic [CNT_W:0]   walk_p2;
   logic [EXT_W-1:0] fill_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff <= walk_in;
   end

   assign pos_ext    = CMP_W'(req_position);
   assign count_ext  = CMP_W'(count_ff);
   assign pos_p1     = {1'b0, pos_ext} + (CMP_W + 1)'(1);
   assign in_range   = pos_ext < count_ext;
   assign more_above = pos_p1 < {1'b0, count_ext};
   assign count_dec  = count_ff - CNT_W'(1);
   assign walk_p2    = {1'b0, walk_ff} + (CNT_W + 1)'(2);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      walk_in   = walk_ff;
      req_ready = 1'b0;
      done      = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = pos_ext[IDX_W-1:0];
      wr_data   = req_word_in;
      rd_addr   = pos_ext[IDX_W-1:0];
      result.word_out = '0;
      result.status   = STAT_OK;

      accept = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = out_free;
            accept    = req_valid && out_free;
            if (accept) begin
               case (req_type)
                  REQ_PUSH: begin
                     done = 1'b1;
                     if (count_ff == FULL_COUNT) begin
                        result.status = STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[IDX_W-1:0];
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  REQ_POP: begin
                     if (count_ff == '0) begin
                        done          = 1'b1;
                        result.status = STAT_RANGE;
                     end else begin
                        count_in = count_dec;
                        rd_addr  = count_dec[IDX_W-1:0];
                        state_in = ST_READ;
                     end
                  end
                  REQ_GET: begin
                     if (!in_range) begin
                        done          = 1'b1;
                        result.status = STAT_RANGE;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  REQ_SET: begin
                     done = 1'b1;
                     if (!in_range) begin
                        result.status = STAT_RANGE;
                     end else begin
                        wr_en = 1'b1;
                     end
                  end
                  REQ_ERASE: begin
                     if (!in_range) begin
                        done          = 1'b1;
                        result.status = STAT_RANGE;
                     end else if (more_above) begin
                        // fetch the entry above, it moves down next cycle
                        rd_addr  = pos_p1[IDX_W-1:0];
                        walk_in  = pos_ext[CNT_W-1:0];
                        state_in = ST_ERASE;
                     end else begin
                        done     = 1'b1;
                        count_in = count_dec;
                     end
                  end
                  default: begin
                     done          = 1'b1;
                     result.status = STAT_RANGE;
                  end
               endcase
            end
         end
         ST_READ: begin
            done            = 1'b1;
            result.word_out = rd_data;
            state_in        = ST_IDLE;
         end
         ST_ERASE: begin
            wr_en   = 1'b1;
            wr_addr = walk_ff[IDX_W-1:0];
            wr_data = rd_data;
            if (walk_p2 < {1'b0, count_ff}) begin
               rd_addr = walk_p2[IDX_W-1:0];
               walk_in = walk_ff + CNT_W'(1);
            end else begin
               done     = 1'b1;
               count_in = count_dec;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      fill_ext          = EXT_W'(count_in);
      result.fill_count = fill_ext[FILL_W-1:0];
   end

endmodule

`default_nettype wire

[rtl/core/indexed_vector_store.sv]
// ----------------------------------------------------------------------------
// indexed_vector_store
// fixed-depth store of signed 32-bit words with a fill count: push, pop,
// get, set and erase by index, one result item per request item
// ----------------------------------------------------------------------------
//
//  channel   ports                                        direction
//  -------   -------------------------------------------  ---------
//  request   req_valid/req_ready, req_type, req_position,  in
//            req_word_in
//  response  rsp_valid/rsp_ready, rsp_word_out,            out
//            rsp_status, rsp_fill_count
//
//  push, set and every error case need no memory read; get and pop wait
//  for the registered read data; erase of position p moves the entries
//  above p down, one entry moved down per cycle through the write port
//  reset clears the fill count, sequencer and output valid flag only; memory
//  contents are not cleared, an entry is always written before it can be read
//  a new item is taken while the previous result sits in the output
//  register as long as that result is taken in the same cycle
//
`default_nettype none

module indexed_vector_store
   import ivs_pkg::*;
#(
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [2:0]                req_type,
   input  wire logic [POS_W-1:0]          req_position,
   input  wire logic signed [WORD_W-1:0]  req_word_in,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [WORD_W-1:0]       rsp_word_out,
   output logic [1:0]                     rsp_status,
   output logic [FILL_W-1:0]              rsp_fill_count
);

   localparam int unsigned IDX_W = $clog2(DEPTH);

   // memory port between sequencer and entry store
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [IDX_W-1:0]  rd_addr;
   logic [WORD_W-1:0] rd_data;

   // finished result from the sequencer
   logic        done;
   ivs_rsp_type result;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   ivs_rsp_type rsp_data_ff;
   logic        out_free;

   ivs_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ivs_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_type     (req_type),
      .req_position (req_position),
      .req_word_in  (req_word_in),
      .out_free     (out_free),
      .done         (done),
      .result       (result),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data)
   );

   // output register is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (done) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload holds until a new result lands
   always_ff @(posedge clock) begin
      if (done) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_word_out   = rsp_data_ff.word_out;
   assign rsp_status     = rsp_data_ff.status;
   assign rsp_fill_count = rsp_data_ff.fill_count;

   // a finished result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      done |-> out_free)
      else $error("result finished while output register still full");

   // a result finished while request ready is high never meets a blocked output register
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_ready && done) |-> !(rsp_valid_ff && !rsp_ready))
      else $error("item accepted with result blocked");

   // failed or non-reading requests return a zero word
   a_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STAT_OK) |-> (rsp_word_out == '0))
      else $error("non-zero word with error status");

   // status code stays within its defined set
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STAT_OK || rsp_status == STAT_RANGE ||
                     rsp_status == STAT_FULL))
      else $error("undefined status code");

endmodule

`default_nettype wire

[tb/sv/indexed_vector_store_test.sv]
// ----------------------------------------------------------------------------
// indexed_vector_store_test
// self-checking bench for the indexed vector store: directed corner items,
// a fill to capacity and back, a long result stall and a random mix of
// push, pop, get, set, erase and unused request codes, all checked against
// a mirror of the store kept inside the bench
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_vector_store_test
   import ivs_pkg::*;
();

   localparam int unsigned STORE_DEPTH = 1024;
   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned TAIL_CYCLES = 40;
   localparam int unsigned RESET_CYCLES = 6;
   localparam int unsigned RANDOM_ITEMS = 550;
   localparam int unsigned STALL_CYCLES = 200;

   // request codes the block does not define, answered with a range status
   localparam logic [2:0] REQ_UNUSED_LO  = 3'd5;
   localparam logic [2:0] REQ_UNUSED_MID = 3'd6;
   localparam logic [2:0] REQ_UNUSED_HI  = 3'd7;

   localparam logic signed [WORD_W-1:0] WORD_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [WORD_W-1:0] WORD_MIN  = 32'sh8000_0000;
   localparam logic signed [WORD_W-1:0] WORD_ONES = -32'sd1;
   localparam logic [POS_W-1:0]         POS_TOP   = POS_W'(STORE_DEPTH - 1);

   // every input known from time zero
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [2:0]                req_type = REQ_PUSH;
   logic [POS_W-1:0]          req_position = '0;
   logic signed [WORD_W-1:0]  req_word_in = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [WORD_W-1:0]  rsp_word_out;
   logic [1:0]                rsp_status;
   logic [FILL_W-1:0]         rsp_fill_count;

   // mirror of the store, updated as each request item is accepted
   logic signed [WORD_W-1:0]  mirror_words [STORE_DEPTH];
   int                        mirror_fill = 0;
   int                        peak_fill = 0;

   // predicted result items, oldest first
   ivs_rsp_type               awaited_results [$];

   // idling switches and the one-off long stall asked of the result side
   bit                        source_idle = 1'b1;
   bit                        sink_idle = 1'b1;
   int                        sink_hold_req = 0;

   int                        fail_count = 0;
   int                        items_sent = 0;
   int                        results_checked = 0;
   int                        erases_sent = 0;
   int                        cycle_count = 0;

   indexed_vector_store #(
      .DEPTH(STORE_DEPTH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_position   (req_position),
      .req_word_in    (req_word_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_word_out   (rsp_word_out),
      .rsp_status     (rsp_status),
      .rsp_fill_count (rsp_fill_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results still awaited",
                  $time, cycle_count, awaited_results.size());
         $display("status: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // mirror of the store: applies one request item and returns its result
   // ------------------------------------------------------------------------
   function automatic ivs_rsp_type apply_request(input logic [2:0] kind,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic signed [WORD_W-1:0] word);
      ivs_rsp_type res;
      res.word_out = '0;
      res.status   = STAT_OK;
      case (kind)
         REQ_PUSH: begin
            if (mirror_fill >= STORE_DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               mirror_words[mirror_fill] = word;
               mirror_fill++;
            end
         end
         REQ_POP: begin
            if (mirror_fill == 0) begin
               res.status = STAT_RANGE;
            end else begin
               mirror_fill--;
               res.word_out = mirror_words[mirror_fill];
            end
         end
         REQ_GET: begin
            if (pos >= mirror_fill) res.status = STAT_RANGE;
            else res.word_out = mirror_words[pos];
         end
         REQ_SET: begin
            if (pos >= mirror_fill) res.status = STAT_RANGE;
            else mirror_words[pos] = word;
         end
         REQ_ERASE: begin
            if (pos >= mirror_fill) begin
               res.status = STAT_RANGE;
            end else begin
               // later entries move down by one, the vacated top slot is cleared
               for (int i = pos; i + 1 < mirror_fill; i++)
                  mirror_words[i] = mirror_words[i + 1];
               mirror_words[mirror_fill - 1] = '0;
               mirror_fill--;
            end
         end
         default: res.status = STAT_RANGE;
      endcase
      if (mirror_fill > peak_fill) peak_fill = mirror_fill;
      res.fill_count = FILL_W'(mirror_fill);
      return res;
   endfunction

   // at least half of all draws give no wait at all, so back-to-back stretches occur
   function automatic int draw_wait(input bit enabled);
      if (!enabled) return 0;
      if ($urandom_range(0, 1) != 0) return 0;
      return $urandom_range(0, 16);
   endfunction

   // ------------------------------------------------------------------------
   // request side: offers one item and holds it until accepted
   // valid stays high across back-to-back items, so it is only lowered for
   // a real gap
   // ------------------------------------------------------------------------
   task automatic send_item(input logic [2:0] kind, input logic [POS_W-1:0] pos,
                            input logic signed [WORD_W-1:0] word);
      int gap;
      gap = draw_wait(source_idle);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_type     <= kind;
      req_position <= pos;
      req_word_in  <= word;
      do @(posedge clock); while (!req_ready);
      awaited_results.push_back(apply_request(kind, pos, word));
      items_sent++;
      if (kind == REQ_ERASE) erases_sent++;
   endtask

   // sender pauses until every predicted result has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   // well-formed traffic: fill hovers around a few dozen entries and most
   // indices land inside the store, with unused codes and wild indices mixed in
   task automatic send_random_item();
      int               pick;
      int               push_weight;
      logic [2:0]       kind;
      logic [POS_W-1:0] pos;
      push_weight = (mirror_fill < 48) ? 35 : 12;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         kind = REQ_UNUSED_LO + 3'($urandom_range(0, REQ_UNUSED_HI - REQ_UNUSED_LO));
      end else if (pick < 4 + push_weight) begin
         kind = REQ_PUSH;
      end else if (pick < 18 + push_weight) begin
         kind = REQ_POP;
      end else begin
         case ($urandom_range(0, 2))
            0:       kind = REQ_GET;
            1:       kind = REQ_SET;
            default: kind = REQ_ERASE;
         endcase
      end
      if (mirror_fill != 0 && $urandom_range(0, 4) != 0)
         pos = POS_W'($urandom_range(0, mirror_fill - 1));
      else
         pos = POS_W'($urandom);
      send_item(kind, pos, $urandom);
   endtask

   // ------------------------------------------------------------------------
   // result side: random ready, one long stall on request, field checks
   // ------------------------------------------------------------------------
   task automatic check_result();
      ivs_rsp_type want;
      results_checked++;
      if (awaited_results.size() == 0) begin
         $display("%0t: result with none awaited: word %0d status %0d fill %0d",
                  $time, rsp_word_out, rsp_status, rsp_fill_count);
         fail_count++;
      end else begin
         want = awaited_results.pop_front();
         if (rsp_word_out !== want.word_out) begin
            $display("%0t: word_out expected %0d actual %0d",
                     $time, want.word_out, rsp_word_out);
            fail_count++;
         end
         if (rsp_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, rsp_status);
            fail_count++;
         end
         if (rsp_fill_count !== want.fill_count) begin
            $display("%0t: fill_count expected %0d actual %0d",
                     $time, want.fill_count, rsp_fill_count);
            fail_count++;
         end
      end
   endtask

   initial begin : result_sink
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait(sink_idle);
         // a pending long hold replaces the ordinary draw, counted here
         if (sink_hold_req != 0) begin
            stall = sink_hold_req;
            sink_hold_req = 0;
         end
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         check_result();
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // empty-store errors, word extremes, set and erase in the middle, erase of
   // the last entry, unused codes and pop back down to empty
   task automatic test_directed_cases();
      source_idle = 1'b1;
      sink_idle   = 1'b1;
      send_item(REQ_POP,   '0, '0);
      send_item(REQ_GET,   '0, '0);
      send_item(REQ_SET,   '0, WORD_MAX);
      send_item(REQ_ERASE, '0, '0);
      send_item(REQ_PUSH,  '0, WORD_MAX);
      send_item(REQ_PUSH,  POS_TOP, WORD_MIN);
      send_item(REQ_PUSH,  '0, '0);
      send_item(REQ_PUSH,  '0, WORD_ONES);
      send_item(REQ_GET,   POS_W'(0), '0);
      send_item(REQ_GET,   POS_W'(3), '0);
      send_item(REQ_GET,   POS_W'(4), '0);
      send_item(REQ_GET,   POS_TOP, '0);
      send_item(REQ_SET,   POS_W'(1), 32'sh5A5A_A5A5);
      send_item(REQ_GET,   POS_W'(1), '0);
      send_item(REQ_ERASE, POS_W'(1), '0);
      send_item(REQ_GET,   POS_W'(1), '0);
      send_item(REQ_ERASE, POS_W'(2), '0);
      send_item(REQ_SET,   POS_W'(2), WORD_ONES);
      send_item(REQ_UNUSED_LO, POS_W'(1), WORD_MAX);
      send_item(REQ_UNUSED_MID, '0, '0);
      send_item(REQ_UNUSED_HI, POS_TOP, WORD_ONES);
      send_item(REQ_POP,   '0, '0);
      send_item(REQ_POP,   '0, '0);
      send_item(REQ_POP,   '0, '0);
      wait_for_drain();
   endtask

   // push to capacity, push when full, work on the top slot, erase at the
   // bottom of a full store (the longest shift), then pop back to empty
   task automatic test_full_store();
      source_idle = 1'b0;
      sink_idle   = 1'b0;
      while (mirror_fill < STORE_DEPTH)
         send_item(REQ_PUSH, POS_W'($urandom), $urandom);
      send_item(REQ_PUSH,  '0, WORD_MAX);
      send_item(REQ_PUSH,  '0, WORD_MIN);
      send_item(REQ_GET,   POS_TOP, '0);
      send_item(REQ_SET,   POS_TOP, WORD_MIN);
      send_item(REQ_GET,   POS_TOP, '0);
      send_item(REQ_ERASE, '0, '0);
      send_item(REQ_GET,   '0, '0);
      send_item(REQ_GET,   POS_W'(STORE_DEPTH - 2), '0);
      send_item(REQ_PUSH,  '0, WORD_ONES);
      send_item(REQ_ERASE, POS_TOP, '0);
      send_item(REQ_ERASE, POS_W'(STORE_DEPTH / 2), '0);
      sink_idle = 1'b1;
      while (mirror_fill != 0)
         send_item(($urandom_range(0, 7) == 0) ? REQ_GET : REQ_POP,
                   POS_W'($urandom_range(0, mirror_fill - 1)), $urandom);
      send_item(REQ_POP, '0, '0);
      wait_for_drain();
   endtask

   // the result side holds off for a long stretch while items keep coming,
   // so the block backs up and drops its request ready
   task automatic test_backpressure();
      source_idle   = 1'b0;
      sink_idle     = 1'b0;
      sink_hold_req = STALL_CYCLES;
      repeat (40) send_random_item();
      wait_for_drain();
   endtask

   // random traffic in phases, each phase with its own idling on either side
   task automatic test_random_mix(input int count);
      for (int n = 0; n < count; n++) begin
         if (n % 50 == 0) begin
            source_idle = ($urandom_range(0, 3) != 0);
            sink_idle   = ($urandom_range(0, 3) != 0);
         end
         send_random_item();
      end
      wait_for_drain();
   endtask

   initial begin : run_tests
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_full_store();
      test_backpressure();
      test_random_mix(RANDOM_ITEMS);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("summary: %0d request items, %0d results checked, %0d erases",
               items_sent, results_checked, erases_sent);
      $display("summary: fill reached %0d of %0d, long result stall of %0d cycles",
               peak_fill, STORE_DEPTH, STALL_CYCLES);
      if (fail_count == 0 && awaited_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
